// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge, disabled while reset is asserted.
`define TFS_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define TFS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/tfs_pkg.sv
// ----------------------------------------------------------------------------
// Tune frame serializer package
// Frame layout constants, parallel mode codes and the frame descriptor type.
// ----------------------------------------------------------------------------
package tfs_pkg;

	localparam int unsigned FRAME_LEN  = 25;
	localparam int unsigned ADDR_BITS  = 4;
	localparam int unsigned FIELD_BITS = FRAME_LEN - ADDR_BITS - 1;
	localparam int unsigned POS_BITS   = 5;
	localparam int unsigned WORD_BITS  = 17;
	localparam int unsigned FREQ_BITS  = 16;
	localparam int unsigned CHAN_BITS  = 3;

	localparam logic [FREQ_BITS-1:0] FREQ_BASE = 16'd479;
	// Register address 1, sent least significant bit first.
	localparam logic [ADDR_BITS-1:0] ADDR_CODE = 4'd1;
	localparam logic [POS_BITS-1:0]  LAST_POS  = POS_BITS'(FRAME_LEN - 1);

	typedef logic [FIELD_BITS-1:0] field_t;

	typedef enum logic [1:0] {
		LEG_OFF    = 2'd0,
		LEG_DIRECT = 2'd1,
		LEG_INVERT = 2'd2
	} parallel_mode_t;

	typedef struct packed {
		logic [FRAME_LEN-1:0] frame;
		logic                 active;
		logic [CHAN_BITS-1:0] levels;
	} frame_desc_t;

endpackage

// File: rtl/vrx_tune_frame_serializer.sv
// ----------------------------------------------------------------------------
// Video receiver tune frame serializer
// Turns a tune request into a 25-bit synthesizer write frame, one bit a beat.
//
//   Channel  Handshake            Beat contents
//   cfg      cfg_valid/cfg_ready  parallel_mode
//   in       in_valid/in_stall    frequency_mhz, channel_number
//   out      out_valid/out_stall  frame_bit, bit_position, last_bit,
//                                 legacy_active, legacy_levels
//
// Each request gives 25 output beats, one per cycle without stalls; the bit
// counter of the back end sets this.
// An accepted request passes the queue entry and the current-frame register before its first bit is output.
// A two-entry descriptor queue lets requests be accepted while a frame shifts.
// Reset empties the queue and output register and sets the mode register to 0.
// An output stall holds the current beat and the bit counter.
// ----------------------------------------------------------------------------
module vrx_tune_frame_serializer #(
	parameter int unsigned DATA_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [1:0]                     parallel_mode,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [tfs_pkg::FREQ_BITS-1:0]  frequency_mhz,
	input  logic [tfs_pkg::CHAN_BITS-1:0]  channel_number,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           frame_bit,
	output logic [tfs_pkg::POS_BITS-1:0]   bit_position,
	output logic                           last_bit,
	output logic                           legacy_active,
	output logic [tfs_pkg::CHAN_BITS-1:0]  legacy_levels
);

	logic                 q_push;
	logic                 q_pop;
	logic                 q_full;
	logic                 q_not_empty;
	tfs_pkg::frame_desc_t wr_desc;
	tfs_pkg::frame_desc_t rd_desc;

	tfs_front #(
		.DATA_BITS (DATA_BITS)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.parallel_mode  (parallel_mode),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.frequency_mhz  (frequency_mhz),
		.channel_number (channel_number),
		.q_full         (q_full),
		.q_push         (q_push),
		.q_desc         (wr_desc)
	);

	tfs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.wr_desc   (wr_desc),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.rd_desc   (rd_desc)
	);

	tfs_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_not_empty   (q_not_empty),
		.q_desc        (rd_desc),
		.q_pop         (q_pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.frame_bit     (frame_bit),
		.bit_position  (bit_position),
		.last_bit      (last_bit),
		.legacy_active (legacy_active),
		.legacy_levels (legacy_levels)
	);

endmodule

// File: rtl/tfs_front.sv
// ----------------------------------------------------------------------------
// Tune frame serializer front end
// Holds the parallel mode register, accepts tune requests and builds the
// complete frame descriptor for each one.
// ----------------------------------------------------------------------------
module tfs_front #(
	parameter int unsigned DATA_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [1:0]                     parallel_mode,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [tfs_pkg::FREQ_BITS-1:0]  frequency_mhz,
	input  logic [tfs_pkg::CHAN_BITS-1:0]  channel_number,
	input  logic                           q_full,
	output logic                           q_push,
	output tfs_pkg::frame_desc_t           q_desc
);

	localparam tfs_pkg::field_t DATA_MASK = tfs_pkg::field_t'((64'd1 << DATA_BITS) - 64'd1);

	logic [1:0]                      mode_q;
	logic [tfs_pkg::FREQ_BITS-1:0]   freq_clamp;
	logic [tfs_pkg::FREQ_BITS-1:0]   freq_off;
	logic [tfs_pkg::WORD_BITS-1:0]   word;
	tfs_pkg::field_t                 field;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= tfs_pkg::LEG_OFF;
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= parallel_mode;
		end
	end

	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;

	// Frequencies below the band base clamp to it, giving a zero word.
	assign freq_clamp = (frequency_mhz < tfs_pkg::FREQ_BASE) ? tfs_pkg::FREQ_BASE
		: frequency_mhz;
	assign freq_off   = freq_clamp - tfs_pkg::FREQ_BASE;

	// v = off/2; N = v[14:5] lands at bit 7, A = v[4:0] stays at bit 0.
	assign word  = {freq_off[15:6], 2'b00, freq_off[5:1]};
	assign field = tfs_pkg::field_t'(word) & DATA_MASK;

	always_comb begin
		q_desc.frame = {field, 1'b1, tfs_pkg::ADDR_CODE};
		case (mode_q)
			tfs_pkg::LEG_DIRECT: begin
				q_desc.active = 1'b1;
				q_desc.levels = channel_number;
			end
			tfs_pkg::LEG_INVERT: begin
				q_desc.active = 1'b1;
				q_desc.levels = ~channel_number;
			end
			default: begin
				q_desc.active = 1'b0;
				q_desc.levels = '0;
			end
		endcase
	end

endmodule

// File: rtl/tfs_queue.sv
// ----------------------------------------------------------------------------
// Tune frame serializer descriptor queue
// Two-entry queue of frame descriptors between the front and back ends.
// ----------------------------------------------------------------------------
module tfs_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  tfs_pkg::frame_desc_t  wr_desc,
	output logic                  full,
	input  logic                  pop,
	output logic                  not_empty,
	output tfs_pkg::frame_desc_t  rd_desc
);

	tfs_pkg::frame_desc_t entry_q [2];
	logic                 wr_ptr_q;
	logic                 rd_ptr_q;
	logic [1:0]           count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign rd_desc   = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wr_desc;
		end
	end

endmodule

// File: rtl/tfs_back.sv
// ----------------------------------------------------------------------------
// Tune frame serializer back end
// Shifts each queued frame out one bit per beat into a registered output.
// ----------------------------------------------------------------------------
module tfs_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           q_not_empty,
	input  tfs_pkg::frame_desc_t           q_desc,
	output logic                           q_pop,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           frame_bit,
	output logic [tfs_pkg::POS_BITS-1:0]   bit_position,
	output logic                           last_bit,
	output logic                           legacy_active,
	output logic [tfs_pkg::CHAN_BITS-1:0]  legacy_levels
);

	logic                               cur_valid_q;
	logic [tfs_pkg::FRAME_LEN-1:0]      cur_frame_q;
	logic [tfs_pkg::POS_BITS-1:0]       cur_pos_q;
	logic                               cur_active_q;
	logic [tfs_pkg::CHAN_BITS-1:0]      cur_levels_q;
	logic                               out_valid_q;
	logic                               frame_bit_q;
	logic [tfs_pkg::POS_BITS-1:0]       bit_position_q;
	logic                               last_bit_q;
	logic                               legacy_active_q;
	logic [tfs_pkg::CHAN_BITS-1:0]      legacy_levels_q;
	logic                               adv;
	logic                               cur_last;

	assign adv      = !out_valid_q || !out_stall;
	assign cur_last = (cur_pos_q == tfs_pkg::LAST_POS);
	// The next frame loads while the last bit of the current one moves out.
	assign q_pop    = q_not_empty && (!cur_valid_q || (adv && cur_last));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= cur_valid_q;
			end
			if (q_pop) begin
				cur_valid_q <= 1'b1;
			end else if (adv && cur_last) begin
				cur_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && cur_valid_q) begin
			frame_bit_q     <= cur_frame_q[0];
			bit_position_q  <= cur_pos_q;
			last_bit_q      <= cur_last;
			legacy_active_q <= cur_active_q;
			legacy_levels_q <= cur_levels_q;
		end
		if (q_pop) begin
			cur_frame_q  <= q_desc.frame;
			cur_pos_q    <= '0;
			cur_active_q <= q_desc.active;
			cur_levels_q <= q_desc.levels;
		end else if (adv && cur_valid_q) begin
			cur_frame_q <= cur_frame_q >> 1;
			cur_pos_q   <= cur_pos_q + tfs_pkg::POS_BITS'(1);
		end
	end

	assign out_valid     = out_valid_q;
	assign frame_bit     = frame_bit_q;
	assign bit_position  = bit_position_q;
	assign last_bit      = last_bit_q;
	assign legacy_active = legacy_active_q;
	assign legacy_levels = legacy_levels_q;

endmodule

// File: rtl/tfs_checker.sv
// ----------------------------------------------------------------------------
// Tune frame serializer checker
// Port-level assertions on the output beat stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tfs_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic                           frame_bit,
	input  logic [tfs_pkg::POS_BITS-1:0]   bit_position,
	input  logic                           last_bit,
	input  logic                           legacy_active,
	input  logic [tfs_pkg::CHAN_BITS-1:0]  legacy_levels
);

	`TFS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid, "output beat dropped while stalled")

	`TFS_ASSERT(a_last_pos, clk, arst_n, !out_valid || (last_bit == (bit_position == tfs_pkg::LAST_POS)), "last_bit does not match the final position")

	`TFS_ASSERT(a_header, clk, arst_n, !out_valid || !(bit_position == '0 || bit_position == 5'd4) || frame_bit, "address or write bit is not one")

	`TFS_ASSERT_NEXT(a_frame_run, clk, arst_n, out_valid && !out_stall && !last_bit, out_valid && (bit_position == $past(bit_position) + 5'd1), "frame bits are not contiguous")

	`TFS_ASSERT(a_legacy_idle, clk, arst_n, !out_valid || legacy_active || (legacy_levels == '0), "legacy levels driven while inactive")

endmodule

bind vrx_tune_frame_serializer tfs_checker u_tfs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.frame_bit     (frame_bit),
	.bit_position  (bit_position),
	.last_bit      (last_bit),
	.legacy_active (legacy_active),
	.legacy_levels (legacy_levels)
);
